### sv/ics_pkg.sv
`default_nettype none

package ics_pkg;

  localparam logic [7:0] UNDERSCORE_CHAR = 8'h5F;

  // Character classes of one byte; a byte of 128 or above belongs to none
  typedef struct packed {
    logic lower;
    logic upper;
    logic digit;
    logic under;
  } char_class_t;

  typedef enum logic [2:0] {
    SN_START,
    SN_PRE1,
    SN_PRE2,
    SN_UNDER,
    SN_LETTER,
    SN_DIGITS,
    SN_REJECT
  } snake_phase_t;

  typedef enum logic [2:0] {
    UP_START,
    UP_UNDER,
    UP_LETTER,
    UP_DIGITS,
    UP_REJECT
  } upper_phase_t;

  typedef enum logic [2:0] {
    CA_START,
    CA_PRE1,
    CA_PRE2,
    CA_LOWER,
    CA_UPPER,
    CA_REJECT
  } camel_phase_t;

  typedef enum logic [1:0] {
    PA_START,
    PA_LOWER,
    PA_UPPER,
    PA_REJECT
  } pascal_phase_t;

  // Per-style pass flags, bit order matches the enable mask
  typedef struct packed {
    logic pascal;
    logic camel;
    logic upper_snake;
    logic snake;
  } style_hits_t;

endpackage : ics_pkg

`default_nettype wire

### sv/ics_char_class.sv
`default_nettype none

module ics_char_class (
  input  wire logic [7:0]          char_byte,
  output ics_pkg::char_class_t     char_class
);
  import ics_pkg::*;

  // Full-byte compares, so non-ASCII bytes fall in no class
  always_comb begin
    char_class.lower = (char_byte >= 8'h61) && (char_byte <= 8'h7A);
    char_class.upper = (char_byte >= 8'h41) && (char_byte <= 8'h5A);
    char_class.digit = (char_byte >= 8'h30) && (char_byte <= 8'h39);
    char_class.under = (char_byte == UNDERSCORE_CHAR);
  end

endmodule : ics_char_class

`default_nettype wire

### sv/ics_recog.sv
`default_nettype none

module ics_recog (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step,
  input  wire logic                 name_last,
  input  wire ics_pkg::char_class_t char_class,
  output ics_pkg::style_hits_t      hits
);
  import ics_pkg::*;

  snake_phase_t  snake_r,  snake_nxt;
  upper_phase_t  upper_r,  upper_nxt;
  camel_phase_t  camel_r,  camel_nxt;
  pascal_phase_t pascal_r, pascal_nxt;

  always_comb begin
    case (snake_r)
      SN_START: begin
        if (char_class.under) snake_nxt = SN_PRE1;
        else if (char_class.lower) snake_nxt = SN_LETTER;
        else snake_nxt = SN_REJECT;
      end
      SN_PRE1: begin
        if (char_class.under) snake_nxt = SN_PRE2;
        else if (char_class.lower) snake_nxt = SN_LETTER;
        else snake_nxt = SN_REJECT;
      end
      SN_PRE2, SN_UNDER: begin
        snake_nxt = char_class.lower ? SN_LETTER : SN_REJECT;
      end
      SN_LETTER: begin
        if (char_class.lower) snake_nxt = SN_LETTER;
        else if (char_class.under) snake_nxt = SN_UNDER;
        else if (char_class.digit) snake_nxt = SN_DIGITS;
        else snake_nxt = SN_REJECT;
      end
      SN_DIGITS: begin
        snake_nxt = char_class.digit ? SN_DIGITS : SN_REJECT;
      end
      default: snake_nxt = SN_REJECT;
    endcase
  end

  always_comb begin
    case (upper_r)
      UP_START, UP_UNDER: begin
        upper_nxt = char_class.upper ? UP_LETTER : UP_REJECT;
      end
      UP_LETTER: begin
        if (char_class.upper) upper_nxt = UP_LETTER;
        else if (char_class.under) upper_nxt = UP_UNDER;
        else if (char_class.digit) upper_nxt = UP_DIGITS;
        else upper_nxt = UP_REJECT;
      end
      UP_DIGITS: begin
        upper_nxt = char_class.digit ? UP_DIGITS : UP_REJECT;
      end
      default: upper_nxt = UP_REJECT;
    endcase
  end

  always_comb begin
    case (camel_r)
      CA_START: begin
        if (char_class.under) camel_nxt = CA_PRE1;
        else if (char_class.lower) camel_nxt = CA_LOWER;
        else camel_nxt = CA_REJECT;
      end
      CA_PRE1: begin
        if (char_class.under) camel_nxt = CA_PRE2;
        else if (char_class.lower) camel_nxt = CA_LOWER;
        else camel_nxt = CA_REJECT;
      end
      CA_PRE2: begin
        camel_nxt = char_class.lower ? CA_LOWER : CA_REJECT;
      end
      CA_LOWER: begin
        if (char_class.lower || char_class.digit) camel_nxt = CA_LOWER;
        else if (char_class.upper) camel_nxt = CA_UPPER;
        else camel_nxt = CA_REJECT;
      end
      CA_UPPER: begin
        if (char_class.upper || char_class.digit) camel_nxt = CA_UPPER;
        else if (char_class.lower) camel_nxt = CA_LOWER;
        else camel_nxt = CA_REJECT;
      end
      default: camel_nxt = CA_REJECT;
    endcase
  end

  always_comb begin
    case (pascal_r)
      PA_START: begin
        pascal_nxt = char_class.upper ? PA_UPPER : PA_REJECT;
      end
      PA_LOWER: begin
        if (char_class.lower || char_class.digit) pascal_nxt = PA_LOWER;
        else if (char_class.upper) pascal_nxt = PA_UPPER;
        else pascal_nxt = PA_REJECT;
      end
      PA_UPPER: begin
        if (char_class.upper || char_class.digit) pascal_nxt = PA_UPPER;
        else if (char_class.lower) pascal_nxt = PA_LOWER;
        else pascal_nxt = PA_REJECT;
      end
      default: pascal_nxt = PA_REJECT;
    endcase
  end

  // Flags of the state after the current byte
  always_comb begin
    hits.snake       = (snake_nxt != SN_REJECT);
    hits.upper_snake = (upper_nxt != UP_REJECT);
    hits.camel       = (camel_nxt != CA_REJECT);
    hits.pascal      = (pascal_nxt != PA_REJECT);
  end

  // Advance on each consumed byte; restart after the last byte of a name
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snake_r  <= SN_START;
      upper_r  <= UP_START;
      camel_r  <= CA_START;
      pascal_r <= PA_START;
    end else if (step) begin
      if (name_last) begin
        snake_r  <= SN_START;
        upper_r  <= UP_START;
        camel_r  <= CA_START;
        pascal_r <= PA_START;
      end else begin
        snake_r  <= snake_nxt;
        upper_r  <= upper_nxt;
        camel_r  <= camel_nxt;
        pascal_r <= pascal_nxt;
      end
    end
  end

endmodule : ics_recog

`default_nettype wire

### sv/identifier_case_style_checker.sv
`default_nettype none

// Identifier case style checker. Stream in the bytes of one identifier, one
// byte per transfer, with in_tlast on the final byte. Four recognizers
// (snake case, upper snake case, camel case, Pascal case) run side by side; a
// byte they do not allow, or any byte of 128 and above, rejects that style for
// the rest of the name. One result transfer follows each final byte and
// carries the four style flags plus an any-match flag over the styles enabled
// in cfg_wdata (bit0 snake, bit1 upper snake, bit2 camel, bit3 pascal; reset
// value all enabled). Throughput is one byte per clock while no final byte is
// stalled: each byte is held in the input register, where the recognizer state
// update is done, and a name's result is loaded into the output register when
// its last byte is consumed there. Back-pressure on the result side stalls only
// final bytes, and bytes behind a stalled one wait; other bytes keep flowing
// while a result waits. Write the mask only while no name is in flight.
module identifier_case_style_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // byte channel
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] name_byte
  input  wire logic       in_tlast,   // name_last
  // result channel
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic      [7:0] out_tdata,  // [0] snake_ok, [1] upper_snake_ok,
                                      // [2] camel_ok, [3] pascal_ok,
                                      // [4] any_enabled_match, [7:5] zero
  // style enable mask
  input  wire logic       cfg_wen,
  input  wire logic [3:0] cfg_wdata
);
  import ics_pkg::*;

  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        in_last_r;

  logic        out_valid_r;
  style_hits_t out_hits_r;
  logic        out_any_r;

  logic [3:0]  mask_r;

  char_class_t char_class;
  style_hits_t hits;
  logic        out_free;
  logic        step;

  // The output register can take a new result when empty or being drained
  assign out_free  = !out_valid_r || out_tready;
  // Consume the held byte unless it is a final byte with nowhere to go
  assign step      = in_valid_r && (!in_last_r || out_free);
  assign in_tready = !in_valid_r || step;

  ics_char_class u_class (
    .char_byte  (in_byte_r),
    .char_class (char_class)
  );

  ics_recog u_recog (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .name_last  (in_last_r),
    .char_class (char_class),
    .hits       (hits)
  );

  // Mask register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= 4'hF;
    end else if (cfg_wen) begin
      mask_r <= cfg_wdata;
    end
  end

  // Input register: hold the byte until the recognizers consume it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // Result register: load on a consumed final byte, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_last_r) begin
      out_hits_r <= hits;
      out_any_r  <= |(hits & mask_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_any_r, out_hits_r};

endmodule : identifier_case_style_checker

`default_nettype wire
